// ===== hw/rtl/aepc_pkg.sv =====
// ---------------------------------------------------------------------------
// Adjacent equal pair counter package
// Transaction types, fixed field widths and controller states used by the
// counter's top module.
// ---------------------------------------------------------------------------
`default_nettype none

package aepc_pkg;

  localparam int IDX_W     = 10;
  localparam int COLOR_W   = 16;
  localparam int CNT_OUT_W = 10;
  localparam int LEN_W     = 11;

  typedef struct packed {
    logic [IDX_W-1:0]   index;
    logic [COLOR_W-1:0] color;
  } aepc_in_t;

  typedef struct packed {
    logic [CNT_OUT_W-1:0] pair_count;
    logic                 bad_index;
  } aepc_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_L,
    ST_RD_C,
    ST_RD_R,
    ST_CALC
  } aepc_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/aepc_store.sv =====
// ---------------------------------------------------------------------------
// Colour store
// Simple dual-port synchronous memory holding one colour label per position, with
// a registered read and one write per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module aepc_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 16
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/aepc_pair_update.sv =====
// ---------------------------------------------------------------------------
// Pair count update
// Removes the equal pairs that a position forms with its neighbours under the
// old colour and adds those it forms under the new colour.
// ---------------------------------------------------------------------------
`default_nettype none

module aepc_pair_update #(
  parameter int CB = 16,
  parameter int CW = 10
) (
  input  wire logic [CB-1:0] left,
  input  wire logic [CB-1:0] cur,
  input  wire logic [CB-1:0] right,
  input  wire logic [CB-1:0] col,
  input  wire logic          has_left,
  input  wire logic          has_right,
  input  wire logic [CW-1:0] total,
  output logic               changed,
  output logic      [CW-1:0] total_upd
);

  logic [1:0]    old_pairs;
  logic [1:0]    new_pairs;
  logic [CW-1:0] reduced;

  always_comb begin
    old_pairs = 2'd0;
    new_pairs = 2'd0;
    if (cur != '0) begin
      old_pairs = {1'b0, has_left && (left == cur)} + {1'b0, has_right && (right == cur)};
    end
    if (col != '0) begin
      new_pairs = {1'b0, has_left && (left == col)} + {1'b0, has_right && (right == col)};
    end
    changed = (cur != col);
    reduced = (total >= CW'(old_pairs)) ? (total - CW'(old_pairs)) : '0;
    total_upd = changed ? (reduced + CW'(new_pairs)) : total;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/adjacent_equal_pair_counter.sv =====
// ---------------------------------------------------------------------------
// Adjacent equal pair counter
// Writes colour labels into a store and keeps a running count of neighbouring
// positions that hold the same nonzero colour.
// ---------------------------------------------------------------------------
//  channel  ports                          handshake
//  input    start, busy, in_data           taken when start && !busy
//  result   out_valid, out_data            one-cycle strobe, no back-pressure
//  config   cfg_valid, cfg_ready, cfg_data taken when cfg_valid && cfg_ready
//
// An in-range transaction makes three reads of the store (left neighbour,
// position, right neighbour), then the update and, if the colour changed, the write.
// An out-of-range index is answered in the cycle after it is taken.
// After reset and after every length write the store is cleared, one entry a
// cycle, across all MAX_LEN entries; busy stays high meanwhile.
// The result strobe cannot be stalled by the receiver.
// ---------------------------------------------------------------------------
`default_nettype none

module adjacent_equal_pair_counter
  import aepc_pkg::*;
#(
  parameter int MAX_LEN    = 1024,
  parameter int COLOR_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire aepc_in_t         in_data,
  output logic                  out_valid,
  output aepc_out_t             out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [LEN_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int CB = COLOR_BITS;
  localparam logic [AW-1:0] CLR_LAST = AW'(MAX_LEN - 1);

  aepc_state_t      state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CB-1:0]    col_r, col_nxt;
  logic [CB-1:0]    left_r, left_nxt;
  logic [CB-1:0]    cur_r, cur_nxt;
  logic [AW-1:0]    total_r, total_nxt;
  logic [LW-1:0]    len_r, len_nxt;
  logic [AW-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  aepc_out_t        out_r, out_nxt;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [CB-1:0] rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [CB-1:0] wr_data;

  logic          in_bad;
  logic [CB-1:0] in_col;
  logic          has_left;
  logic          has_right;
  logic          changed;
  logic [AW-1:0] total_upd;
  logic [LW-1:0] cfg_len;

  aepc_store #(
    .DEPTH (MAX_LEN),
    .AW    (AW),
    .DW    (CB)
  ) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  aepc_pair_update #(
    .CB (CB),
    .CW (AW)
  ) u_update (
    .left      (left_r),
    .cur       (cur_r),
    .right     (rd_data),
    .col       (col_r),
    .has_left  (has_left),
    .has_right (has_right),
    .total     (total_r),
    .changed   (changed),
    .total_upd (total_upd)
  );

  assign in_bad    = 32'(in_data.index) >= 32'(len_r);
  assign in_col    = CB'(in_data.color);
  assign has_left  = (idx_r != '0);
  assign has_right = (32'(idx_r) + 32'd1) < 32'(len_r);
  assign cfg_len   = (cfg_data == '0) ? LW'(1) :
                     (32'(cfg_data) > 32'(MAX_LEN)) ? LW'(MAX_LEN) : LW'(cfg_data);

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = ((state_r == ST_IDLE) && !start) || (state_r == ST_CLEAR);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    col_nxt       = col_r;
    left_nxt      = left_r;
    cur_nxt       = cur_r;
    total_nxt     = total_r;
    len_nxt       = len_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    rd_en         = 1'b0;
    rd_addr       = AW'(idx_r);
    wr_en         = 1'b0;
    wr_addr       = AW'(idx_r);
    wr_data       = col_r;
    case (state_r)
      ST_CLEAR: begin
        wr_en       = 1'b1;
        wr_addr     = clr_cnt_r;
        wr_data     = '0;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (in_bad) begin
            out_valid_nxt      = 1'b1;
            out_nxt.pair_count = CNT_OUT_W'(total_r);
            out_nxt.bad_index  = 1'b1;
          end else begin
            idx_nxt   = in_data.index;
            col_nxt   = in_col;
            state_nxt = ST_RD_L;
          end
        end
      end
      ST_RD_L: begin
        rd_en     = 1'b1;
        rd_addr   = AW'(idx_r) - AW'(1);
        state_nxt = ST_RD_C;
      end
      ST_RD_C: begin
        rd_en     = 1'b1;
        left_nxt  = rd_data;
        state_nxt = ST_RD_R;
      end
      ST_RD_R: begin
        rd_en     = 1'b1;
        rd_addr   = AW'(idx_r) + AW'(1);
        cur_nxt   = rd_data;
        state_nxt = ST_CALC;
      end
      ST_CALC: begin
        wr_en              = changed;
        total_nxt          = total_upd;
        out_valid_nxt      = 1'b1;
        out_nxt.pair_count = CNT_OUT_W'(total_upd);
        out_nxt.bad_index  = 1'b0;
        state_nxt          = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (cfg_valid && cfg_ready) begin
      len_nxt     = cfg_len;
      total_nxt   = '0;
      clr_cnt_nxt = '0;
      state_nxt   = ST_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      total_r     <= '0;
      len_r       <= LW'(MAX_LEN);
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      len_r       <= len_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    col_r  <= col_nxt;
    left_r <= left_nxt;
    cur_r  <= cur_nxt;
    out_r  <= out_nxt;
  end

  // The store is only written while clearing or when an update completes.
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !wr_en)
    else $error("store written while idle");

  a_clear_writes_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> (wr_en && (wr_data == '0)))
    else $error("clearing pass not writing zero");

  a_bad_index_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_bad && !(cfg_valid && cfg_ready))
      |=> (out_valid && out_data.bad_index && !busy))
    else $error("out-of-range transaction not answered at once");

  a_good_index_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_bad && !(cfg_valid && cfg_ready))
      |=> (state_r == ST_RD_L) ##4 (out_valid && !out_data.bad_index))
    else $error("in-range transaction did not complete in five cycles");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    32'(total_r) < 32'(len_r))
    else $error("pair count exceeds the array length");

endmodule

`default_nettype wire
